// ===== rtl/core/lcdw_pkg.sv =====
// Shared types and codes for the character LCD bus write sequencer.
package lcdw_pkg;

	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 2;

	// operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_CMD    = 2'd1;
	localparam logic [1:0] OP_DATA   = 2'd2;
	localparam logic [1:0] OP_CURSOR = 2'd3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_FOUR_BIT  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_WAIT      = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SET_ADDR  = 2'd3;

	// row count modes
	localparam logic [1:0] ROWS_ONE = 2'd0;
	localparam logic [1:0] ROWS_TWO = 2'd1;

	// DDRAM row start addresses
	localparam logic [7:0] ROW0_OFFSET = 8'h00;
	localparam logic [7:0] ROW1_OFFSET = 8'h40;
	localparam logic [7:0] ROW2_OFFSET = 8'h10;
	localparam logic [7:0] ROW3_OFFSET = 8'h50;

	// bus sequence steps
	localparam logic [2:0] STEP_IDLE    = 3'd0;
	localparam logic [2:0] STEP_SET_RS  = 3'd1;
	localparam logic [2:0] STEP_EN_HI   = 3'd2;
	localparam logic [2:0] STEP_HI_NIB  = 3'd3;
	localparam logic [2:0] STEP_EN_LO   = 3'd4;
	localparam logic [2:0] STEP_EN_HI2  = 3'd5;
	localparam logic [2:0] STEP_LO_NIB  = 3'd6;
	localparam logic [2:0] STEP_EN_LO2  = 3'd7;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [5:0] column;
	} lcdw_in_t;

	typedef struct packed {
		logic       register_select;
		logic       enable_pin;
		logic [7:0] data_pins;
		logic       busy_res;
		logic       rejected;
	} lcdw_out_t;

	typedef struct packed {
		logic        four_bit_mode;
		logic [1:0]  row_count_mode;
		logic [15:0] wait_ticks;
		logic [7:0]  set_address_command;
	} lcdw_cfg_t;

endpackage

// ===== rtl/core/lcdw_seq.sv =====
// Bus step engine: sequence state and the per-word state update.
module lcdw_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  lcdw_pkg::lcdw_in_t  item,
	input  lcdw_pkg::lcdw_cfg_t cfg,
	output lcdw_pkg::lcdw_out_t res
);
	import lcdw_pkg::*;

	logic [2:0]  step_q;
	logic [15:0] wait_q;
	logic [7:0]  byte_q;
	logic        busy_q;
	logic        rs_q;
	logic        en_q;
	logic [7:0]  pins_q;

	logic [2:0]  step_d;
	logic [15:0] wait_d;
	logic [7:0]  byte_d;
	logic        busy_d;
	logic        rs_d;
	logic        en_d;
	logic [7:0]  pins_d;
	logic        rej_d;

	logic [15:0] load_wait;
	logic [15:0] wait_dec;
	logic        row_ok;
	logic [7:0]  row_off;
	logic [7:0]  cur_addr;
	logic [2:0]  last_step;

	assign load_wait = (cfg.wait_ticks == '0) ? 16'd1 : cfg.wait_ticks;
	assign wait_dec  = (wait_q != '0) ? wait_q - 16'd1 : wait_q;
	assign last_step = cfg.four_bit_mode ? STEP_EN_LO2 : STEP_EN_LO;

	always_comb begin
		case (cfg.row_count_mode)
			ROWS_ONE: row_ok = (item.row == 2'd0);
			ROWS_TWO: row_ok = ~item.row[1];
			default:  row_ok = 1'b1;
		endcase
		case (item.row)
			2'd0:    row_off = ROW0_OFFSET;
			2'd1:    row_off = ROW1_OFFSET;
			2'd2:    row_off = ROW2_OFFSET;
			default: row_off = ROW3_OFFSET;
		endcase
		cur_addr = row_ok ? row_off + {2'b00, item.column} : 8'h00;
	end

	always_comb begin
		step_d = step_q;
		wait_d = wait_q;
		byte_d = byte_q;
		busy_d = busy_q;
		rs_d   = rs_q;
		en_d   = en_q;
		pins_d = pins_q;
		rej_d  = 1'b0;
		if (item.operation == OP_TICK) begin
			if (busy_q) begin
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					if (step_q >= last_step) begin
						busy_d = 1'b0;
						step_d = STEP_IDLE;
					end else begin
						step_d = step_q + 3'd1;
						wait_d = load_wait;
						case (step_d)
							STEP_EN_HI:  en_d = 1'b1;
							STEP_HI_NIB: pins_d = cfg.four_bit_mode ?
								{byte_q[7:4], pins_q[3:0]} : byte_q;
							STEP_EN_LO:  en_d = 1'b0;
							STEP_EN_HI2: en_d = 1'b1;
							STEP_LO_NIB: pins_d = {byte_q[3:0], pins_q[3:0]};
							STEP_EN_LO2: en_d = 1'b0;
							default:     ;
						endcase
					end
				end
			end
		end else if (busy_q) begin
			rej_d = 1'b1;
		end else begin
			byte_d = (item.operation == OP_CURSOR) ?
				(cfg.set_address_command | cur_addr) : item.byte_value;
			rs_d   = (item.operation == OP_DATA);
			busy_d = 1'b1;
			step_d = STEP_SET_RS;
			wait_d = load_wait;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			wait_q <= '0;
			byte_q <= '0;
			busy_q <= 1'b0;
			rs_q   <= 1'b0;
			en_q   <= 1'b0;
			pins_q <= '0;
		end else if (step_en) begin
			step_q <= step_d;
			wait_q <= wait_d;
			byte_q <= byte_d;
			busy_q <= busy_d;
			rs_q   <= rs_d;
			en_q   <= en_d;
			pins_q <= pins_d;
		end
	end

	assign res.register_select = rs_d;
	assign res.enable_pin      = en_d;
	assign res.data_pins       = pins_d;
	assign res.busy_res        = busy_d;
	assign res.rejected        = rej_d;

endmodule

// ===== rtl/core/char_lcd_bus_write_sequencer.sv =====
// Top level of the character LCD bus write sequencer.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_item  (operation, byte, row, column)
//  out      out  out_valid/out_ready  out_item (RS, EN, data pins, busy, rejected)
//  cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; each word passes the input
// register, then the step engine updates its state and loads the result register.
// Result valid rises when the word advances from the input register into the result
// register; the step engine is the only state loop and resolves one word per cycle
// while the output is not stalled.
// Reset clears the sequence (idle, pins low) and loads the register defaults.
// A stalled output holds the input register; cfg_ready is always high.
module char_lcd_bus_write_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lcdw_pkg::lcdw_in_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lcdw_pkg::lcdw_out_t               out_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcdw_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [lcdw_pkg::CfgDataW-1:0]     cfg_data
);
	import lcdw_pkg::*;

	lcdw_cfg_t cfg_q;
	lcdw_in_t  item_s1;
	logic      valid_s1;
	logic      advance;
	lcdw_out_t res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 & (~out_valid | out_ready);
	assign in_ready  = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode       <= 1'b1;
			cfg_q.row_count_mode      <= ROWS_TWO;
			cfg_q.wait_ticks          <= 16'd1;
			cfg_q.set_address_command <= 8'h80;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOUR_BIT:  cfg_q.four_bit_mode       <= cfg_data[0];
				REG_ROW_COUNT: cfg_q.row_count_mode      <= cfg_data[1:0];
				REG_WAIT:      cfg_q.wait_ticks          <= cfg_data;
				REG_SET_ADDR:  cfg_q.set_address_command <= cfg_data[7:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
		if (advance)
			out_item <= res;
	end

	lcdw_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

endmodule
